@@ hw/rtl/hrv_pkg.sv @@
// shared types and constants for the hysteretic recruitment volume unit
package hrv_pkg;

   localparam int VolW   = 31;
   localparam int PresW  = 32;
   localparam int CsrAw  = 5;
   localparam int CsrDw  = 32;
   localparam logic [16:0] OneQ16 = 17'h10000;

   typedef enum logic [1:0] {
      OP_EVAL   = 2'd0,
      OP_COMMIT = 2'd1,
      OP_LOAD   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_MIN_VOLUME  = 3'd0,
      REG_MAX_VOLUME  = 3'd1,
      REG_OPEN_PRES   = 3'd2,
      REG_CLOSE_PRES  = 3'd3,
      REG_PRES_SPAN   = 3'd4,
      REG_SW_MARGIN   = 3'd5,
      REG_RELAX       = 3'd6,
      REG_FROZEN      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [30:0] min_volume;
      logic [30:0] max_volume;
      logic signed [31:0] opening_pressure;
      logic signed [31:0] closing_pressure;
      logic [30:0] pressure_span;
      logic [14:0] switch_margin;
      logic [15:0] relax_factor;
      logic        frozen_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [3:0]  unit_index;
      logic signed [31:0] pressure;
      logic [30:0] init_volume;
      logic        init_branch;
   } req_type;

   typedef struct packed {
      logic [30:0] ref_volume;
      logic signed [31:0] volume_slope;
      logic [30:0] target_volume;
      logic        branch;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // take input beat, start memory read
      logic setup;     // compute knees and diffs from read data
      logic div_start; // launch target division
      logic div2_start;// launch slope division
      logic div_step;  // one quotient bit
      logic mul_a;     // r*stored
      logic mul_b;     // (1-r)*target
      logic mul_c;     // relaxed slope and margin
      logic finish;    // final clamp, branch switch, write back
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_div;
      logic is_load;
      logic is_none;
   } sts_type;

endpackage

@@ hw/rtl/hrv_if.sv @@
// valid/ready channel interface
interface hrv_if #(parameter int W = 1) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/hrv_ram.sv @@
// generic simple dual port ram (separate read and write address) with registered read
module hrv_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                              wr_data,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hw/rtl/hrv_ctrl.sv @@
// controller state machine sequencing the shared divider and multiplier
module hrv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output hrv_pkg::cmd_type cmd,
   input  hrv_pkg::sts_type sts
);
   import hrv_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_READ  = 11'b00000000010,
      S_SETUP = 11'b00000000100,
      S_DIV1  = 11'b00000001000,
      S_DIV2S = 11'b00000010000,
      S_DIV2  = 11'b00000100000,
      S_MULA  = 11'b00001000000,
      S_MULB  = 11'b00010000000,
      S_MULC  = 11'b00100000000,
      S_FIN   = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.is_none) state_in = S_IDLE;
            else state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (sts.is_load) begin
               state_in = S_FIN;
            end else if (!sts.need_div) begin
               state_in = S_MULA;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV2S;
            end
         end
         S_DIV2S: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               cmd.div2_start = 1'b1;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_MULA;
         end
         S_MULA: begin
            cmd.mul_a = 1'b1;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.mul_b = 1'b1;
            state_in = S_MULC;
         end
         S_MULC: begin
            cmd.mul_c = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ hw/rtl/hrv_dp.sv @@
// datapath: unit store, restoring divider, shared multiplier, clamps
module hrv_dp #(
   parameter int NumUnits = 16
) (
   input  logic             clock,
   input  hrv_pkg::cfg_type cfg,
   input  hrv_pkg::req_type req,
   input  hrv_pkg::cmd_type cmd,
   output hrv_pkg::sts_type sts,
   output hrv_pkg::rsp_type rsp
);
   import hrv_pkg::*;

   localparam int Aw = (NumUnits > 1) ? $clog2(NumUnits) : 1;
   localparam int QW = 64;

   req_type req_ff;
   logic [Aw-1:0] addr;
   logic [31:0] ram_rd;
   logic        wr_en;
   logic [31:0] wr_data;

   logic [Aw-1:0] uidx_c;
   logic [Aw-1:0] uidx_ff;

   // unit index folded onto the bank through a small constant table
   always_comb begin
      uidx_c = '0;
      for (int i = 0; i < 16; i++) begin
         if (req.unit_index == 4'(i)) uidx_c = Aw'(i % NumUnits);
      end
   end

   assign addr = cmd.capture ? uidx_c : uidx_ff;

   hrv_ram #(.Width(32), .Depth(NumUnits)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(uidx_ff),
      .wr_data(wr_data),
      .rd_addr(addr),
      .rd_data(ram_rd)
   );

   // setup results
   logic [30:0] stored_ff;
   logic        br_ff;
   logic signed [32:0] dpv_ff;    // p - lo
   logic signed [32:0] d_ff;      // max - min
   logic [1:0]  region_ff;        // 0 low knee, 1 high knee, 2 linear
   logic signed [33:0] dpv_c, hi_rel_c;
   logic signed [32:0] lo_c;

   assign lo_c = ram_rd[31] ? 33'(cfg.closing_pressure) : 33'(cfg.opening_pressure);
   assign dpv_c = 34'(req_ff.pressure) - 34'(lo_c);
   assign hi_rel_c = dpv_c - 34'($signed({1'b0, cfg.pressure_span}));

   // divider: unsigned magnitude restoring division, one bit per cycle
   logic [QW-1:0] num_ff, quo_ff;
   logic [QW:0]   rem_ff;
   logic [6:0]    cnt_ff;
   logic          neg_ff;
   logic signed [48:0] q1_ff;     // (p-lo)*d / span
   logic signed [48:0] slope_ff;
   logic [QW:0]   trial;
   logic [QW-1:0] mag_c;
   logic signed [QW:0] num_c;

   always_comb begin
      if (cmd.div_start) num_c = (QW+1)'(dpv_ff) * (QW+1)'(d_ff);
      else               num_c = (QW+1)'(d_ff) <<< 16;
      mag_c = num_c[QW] ? QW'(-num_c) : QW'(num_c);
   end
   assign trial = {rem_ff[QW-1:0], num_ff[QW-1]} - (QW+1)'(cfg.pressure_span);
   assign sts.div_done = (cnt_ff == 7'd0);

   // multiplies spread over the mul_a, mul_b and mul_c steps
   logic [16:0]  omr;
   assign omr = OneQ16 - 17'(cfg.relax_factor);
   logic [30:0]  target_c;
   logic signed [48:0] slope_law;
   logic signed [31:0] slope_sat;
   logic signed [33:0] tgt_full;
   assign tgt_full = 34'($signed({1'b0, cfg.min_volume})) + 34'(q1_ff);
   always_comb begin
      unique case (region_ff)
         2'd0: target_c = cfg.min_volume;
         2'd1: target_c = cfg.max_volume;
         default: target_c = tgt_full[30:0];
      endcase
      slope_law = (region_ff == 2'd2) ? slope_ff : '0;
      if (slope_law > 49'sd2147483647) slope_sat = 32'sh7fffffff;
      else if (slope_law < -49'sd2147483648) slope_sat = 32'sh80000000;
      else slope_sat = slope_law[31:0];
   end

   logic [47:0] vsum_ff;
   logic signed [48:0] vsl_ff;
   logic signed [48:0] delta_ff;
   logic signed [48:0] prod_c;
   logic signed [48:0] dprod_c;
   assign prod_c = 49'(slope_sat) * $signed({32'd0, omr});
   assign dprod_c = 49'(d_ff) * $signed({34'd0, cfg.switch_margin});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
         uidx_ff <= uidx_c;
      end
      if (cmd.setup) begin
         stored_ff <= ram_rd[30:0];
         br_ff <= ram_rd[31];
         dpv_ff <= dpv_c[32:0];
         d_ff <= 33'(cfg.max_volume) - 33'(cfg.min_volume);
         if (dpv_c <= 0) region_ff <= 2'd0;
         else if (hi_rel_c >= 0) region_ff <= 2'd1;
         else region_ff <= 2'd2;
      end
      if (cmd.div_start || cmd.div2_start) begin
         num_ff <= mag_c;
         rem_ff <= '0;
         cnt_ff <= 7'(QW);
         neg_ff <= num_c[QW];
      end else if (cmd.div_step && cnt_ff != 7'd0) begin
         num_ff <= {num_ff[QW-2:0], quo_ff[QW-1]};
         if (!trial[QW]) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[QW-1:0], num_ff[QW-1]};
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 7'd1;
      end
      if (cmd.div_step && cnt_ff == 7'd0 && !cmd.div2_start) begin
         slope_ff <= neg_ff ? -49'($signed({1'b0, quo_ff})) : 49'($signed({1'b0, quo_ff}));
      end
      if (cmd.div2_start) begin
         q1_ff <= neg_ff ? -49'($signed({1'b0, quo_ff})) : 49'($signed({1'b0, quo_ff}));
      end
      if (cmd.mul_a) vsum_ff <= 48'(cfg.relax_factor) * 48'(stored_ff) + 48'd32768;
      if (cmd.mul_b) vsum_ff <= vsum_ff + 48'(omr) * 48'(target_c);
      if (cmd.mul_c) begin
         vsl_ff <= prod_c;
         delta_ff <= dprod_c;
      end
   end

   // final stage
   logic [31:0] v_c;
   logic signed [31:0] vs_c;
   logic        br_c;
   logic signed [33:0] dl;
   logic signed [31:0] vslope_t;
   assign v_c = vsum_ff[47:16];
   assign vslope_t = 32'(vsl_ff / 49'sd65536);
   assign dl = 34'(delta_ff / 49'sd65536);
   rsp_type rsp_ff;
   assign rsp = rsp_ff;
   logic [30:0] vout;
   always_comb begin
      vout = v_c[30:0];
      vs_c = vslope_t;
      if ({1'b0, v_c} <= {2'b0, cfg.min_volume}) begin
         vout = cfg.min_volume; vs_c = '0;
      end else if ({1'b0, v_c} >= {2'b0, cfg.max_volume}) begin
         vout = cfg.max_volume; vs_c = '0;
      end
      br_c = br_ff;
      if (!br_ff && 34'(vout) >= 34'(cfg.max_volume) - dl) br_c = 1'b1;
      else if (br_ff && 34'(vout) <= 34'(cfg.min_volume) + dl) br_c = 1'b0;
      wr_en = 1'b0;
      wr_data = {br_c, vout};
      if (cmd.finish) begin
         unique case (opcode_type'(req_ff.opcode))
            OP_COMMIT: wr_en = 1'b1;
            OP_LOAD: begin
               wr_en = 1'b1;
               wr_data = {req_ff.init_branch, req_ff.init_volume};
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         unique case (opcode_type'(req_ff.opcode))
            OP_LOAD: begin
               rsp_ff <= {req_ff.init_volume, 32'sd0, req_ff.init_volume,
                          req_ff.init_branch};
            end
            OP_COMMIT: rsp_ff <= {vout, vs_c, target_c, br_c};
            default: begin
               if (cfg.frozen_mode) rsp_ff <= {stored_ff, 32'sd0, target_c, br_ff};
               else rsp_ff <= {vout, vs_c, target_c, br_ff};
            end
         endcase
      end
   end

   assign sts.need_div = (region_ff == 2'd2);
   assign sts.is_load = (req_ff.opcode == OP_LOAD);
   assign sts.is_none = (req_ff.opcode == OP_NONE);
endmodule

@@ hw/rtl/hysteretic_recruitment_volume_unit.sv @@
// top level of the hysteretic recruitment volume unit
// Usage: requests arrive on the req channel (valid/ready beat) carrying opcode,
// unit index, pressure and load data; one response beat per evaluate, commit or
// load leaves on the rsp channel. Opcode 3 is dropped with no response.
// Configuration registers are to be written over the csr APB port only while idle;
// the block does not enforce this. One item at a time: ready is high only when
// the unit is idle. A load skips the divisions and multiplies; a pressure on or
// beyond a knee skips the divisions; a pressure between knees runs two 64-bit
// divisions on the shared one-bit-per-cycle divider, followed by three multiply
// steps. Opcode 3 returns the controller to idle straight from the read state.
// A new request is accepted the cycle after the response beat is taken.
// The response stays in its output register until rsp_ready; while the
// receiver stalls no new request is accepted.
// Reset (synchronous, active high) restores register defaults and returns the
// controller to idle. Unit storage holds no defined value until loaded.
module hysteretic_recruitment_volume_unit #(
   parameter int NUM_UNITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   hrv_if.sink         req,
   hrv_if.source       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [hrv_pkg::CsrAw-1:0] csr_paddr,
   input  logic [hrv_pkg::CsrDw-1:0] csr_pwdata,
   output logic [hrv_pkg::CsrDw-1:0] csr_prdata,
   output logic        csr_pready
);
   import hrv_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;
   logic [2:0] ridx;
   assign ridx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{min_volume: 31'd65536, max_volume: 31'd131072,
                    opening_pressure: '0, closing_pressure: '0,
                    pressure_span: 31'd65536, switch_margin: '0,
                    relax_factor: '0, frozen_mode: 1'b0};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_index_type'(ridx))
            REG_MIN_VOLUME: cfg_ff.min_volume <= csr_pwdata[30:0];
            REG_MAX_VOLUME: cfg_ff.max_volume <= csr_pwdata[30:0];
            REG_OPEN_PRES:  cfg_ff.opening_pressure <= csr_pwdata;
            REG_CLOSE_PRES: cfg_ff.closing_pressure <= csr_pwdata;
            REG_PRES_SPAN:  cfg_ff.pressure_span <= csr_pwdata[30:0];
            REG_SW_MARGIN:  cfg_ff.switch_margin <= csr_pwdata[14:0];
            REG_RELAX:      cfg_ff.relax_factor <= csr_pwdata[15:0];
            REG_FROZEN:     cfg_ff.frozen_mode <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(ridx))
         REG_MIN_VOLUME: csr_prdata = {1'b0, cfg_ff.min_volume};
         REG_MAX_VOLUME: csr_prdata = {1'b0, cfg_ff.max_volume};
         REG_OPEN_PRES:  csr_prdata = cfg_ff.opening_pressure;
         REG_CLOSE_PRES: csr_prdata = cfg_ff.closing_pressure;
         REG_PRES_SPAN:  csr_prdata = {1'b0, cfg_ff.pressure_span};
         REG_SW_MARGIN:  csr_prdata = {17'd0, cfg_ff.switch_margin};
         REG_RELAX:      csr_prdata = {16'd0, cfg_ff.relax_factor};
         REG_FROZEN:     csr_prdata = {31'd0, cfg_ff.frozen_mode};
         default:        csr_prdata = '0;
      endcase
   end

   hrv_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd(cmd), .sts(sts)
   );

   hrv_dp #(.NumUnits(NUM_UNITS)) u_dp (
      .clock(clock), .cfg(cfg_ff), .req(req_type'(req.payload)),
      .cmd(cmd), .sts(sts), .rsp(rsp_data)
   );

   assign rsp.payload = rsp_data;
endmodule

@@ hw/rtl/hrv_checker.sv @@
// port-level checks for the hysteretic recruitment volume unit
module hrv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second request taken");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid) else $error("response repeated");
endmodule

bind hysteretic_recruitment_volume_unit hrv_checker u_hrv_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);

@@ test/hysteretic_recruitment_volume_unit_tb.sv @@
// self-checking testbench for the hysteretic recruitment volume unit
module hysteretic_recruitment_volume_unit_tb;
   import hrv_pkg::*;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAw-1:0] csr_paddr;
   logic [CsrDw-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   hrv_if #(.W($bits(req_type))) req_ch ();
   hrv_if #(.W($bits(rsp_type))) rsp_ch ();

   hysteretic_recruitment_volume_unit u_top (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mirror of the register file and the unit bank
   longint vmin, vmax, knee_open, knee_close, pspan, margin, relax;
   bit     frozen;
   logic [30:0] bank_vol [16];
   bit          bank_br [16];

   rsp_type volume_q [$];
   int  n_err, n_checked, n_sent, n_dropped, n_frozen_eval, n_between;
   bit  no_idle, hold_rsp;

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   initial begin
      #(64'd80_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int gap_len();
      if (no_idle) return 0;
      if ($urandom_range(0, 11) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // target, relaxed volume and relaxed slope of one unit at one pressure
   function automatic void volume_law(input bit br, input longint p, input longint stored,
                                      output longint tgt, output longint v,
                                      output longint vs);
      longint lo, d, sl;
      lo = br ? knee_close : knee_open;
      d  = vmax - vmin;
      if (p <= lo) begin
         tgt = vmin; sl = 0;
      end else if (p >= lo + pspan) begin
         tgt = vmax; sl = 0;
      end else begin
         tgt = vmin + ((p - lo) * d) / pspan;
         sl  = sat32((d * 65536) / pspan);
         n_between++;
      end
      v  = (relax * stored + (65536 - relax) * tgt + 32768) / 65536;
      vs = ((65536 - relax) * sl) / 65536;
      if (v <= vmin) begin
         v = vmin; vs = 0;
      end else if (v >= vmax) begin
         v = vmax; vs = 0;
      end
   endfunction

   function automatic bit predict_volume(input req_type it, output rsp_type r);
      longint p, stored, tgt, v, vs, delta;
      int u;
      bit br;
      u = int'(it.unit_index);
      p = longint'($signed(it.pressure));
      stored = longint'({1'b0, bank_vol[u]});
      br = bank_br[u];
      case (opcode_type'(it.opcode))
         OP_EVAL: begin
            volume_law(br, p, stored, tgt, v, vs);
            if (frozen) begin
               v = stored; vs = 0; n_frozen_eval++;
            end
         end
         OP_COMMIT: begin
            delta = (margin * (vmax - vmin)) / 65536;
            volume_law(br, p, stored, tgt, v, vs);
            if (!br && v >= vmax - delta) br = 1'b1;
            else if (br && v <= vmin + delta) br = 1'b0;
            bank_vol[u] = v[30:0];
            bank_br[u]  = br;
         end
         OP_LOAD: begin
            v = longint'({1'b0, it.init_volume});
            tgt = v; vs = 0;
            br = it.init_branch;
            bank_vol[u] = it.init_volume;
            bank_br[u]  = br;
         end
         default: return 1'b0;
      endcase
      r.ref_volume    = v[30:0];
      r.volume_slope  = vs[31:0];
      r.target_volume = tgt[30:0];
      r.branch        = br;
      return 1'b1;
   endfunction

   task automatic send_req(input req_type it, input bit typed, input rsp_type want);
      int n;
      rsp_type r;
      n = gap_len();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
      if (predict_volume(it, r)) volume_q.insert(volume_q.size(), typed ? want : r);
      else n_dropped++;
   endtask

   // block idle: nothing outstanding, then let a dropped beat work through
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (volume_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAw'(idx) << 2;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MIN_VOLUME: vmin       = longint'({1'b0, val[30:0]});
         REG_MAX_VOLUME: vmax       = longint'({1'b0, val[30:0]});
         REG_OPEN_PRES:  knee_open  = longint'($signed(val));
         REG_CLOSE_PRES: knee_close = longint'($signed(val));
         REG_PRES_SPAN:  pspan      = longint'({1'b0, val[30:0]});
         REG_SW_MARGIN:  margin     = longint'(val[14:0]);
         REG_RELAX:      relax      = longint'(val[15:0]);
         REG_FROZEN:     frozen     = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] mn, mx, op, cl, sp, mg, rl, fz);
      csr_write(REG_MIN_VOLUME, mn);
      csr_write(REG_MAX_VOLUME, mx);
      csr_write(REG_OPEN_PRES, op);
      csr_write(REG_CLOSE_PRES, cl);
      csr_write(REG_PRES_SPAN, sp);
      csr_write(REG_SW_MARGIN, mg);
      csr_write(REG_RELAX, rl);
      csr_write(REG_FROZEN, fz);
   endtask

   // mostly pressures around the knees of the unit's current branch
   function automatic req_type random_req();
      req_type it;
      longint lo, p;
      int k;
      k = $urandom_range(0, 99);
      it.opcode = (k < 42) ? OP_EVAL : (k < 82) ? OP_COMMIT : (k < 95) ? OP_LOAD : OP_NONE;
      it.unit_index  = 4'($urandom_range(0, 15));
      it.init_branch = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) it.init_volume = 31'($urandom);
      else it.init_volume = 31'(vmin + longint'($urandom_range(0, 1000)) * (vmax - vmin) / 1000);
      if ($urandom_range(0, 6) == 0) begin
         it.pressure = $urandom;
      end else begin
         lo = bank_br[it.unit_index] ? knee_close : knee_open;
         p  = lo - pspan / 8 + longint'($urandom_range(0, 1200)) * pspan / 1000;
         it.pressure = 32'(sat32(p));
      end
      return it;
   endfunction

   // response side: random stalls, and a long hold on request
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            n = gap_len();
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (volume_q.size() == 0) begin
            $display("%0t: response beat with nothing expected: %h", $time, got);
            n_err++;
         end else begin
            want = volume_q.pop_front();
            n_checked++;
            if (got.ref_volume !== want.ref_volume) begin
               $display("%0t: ref_volume exp %0d got %0d", $time, want.ref_volume,
                        got.ref_volume);
               n_err++;
            end
            if (got.volume_slope !== want.volume_slope) begin
               $display("%0t: volume_slope exp %0d got %0d", $time, want.volume_slope,
                        got.volume_slope);
               n_err++;
            end
            if (got.target_volume !== want.target_volume) begin
               $display("%0t: target_volume exp %0d got %0d", $time, want.target_volume,
                        got.target_volume);
               n_err++;
            end
            if (got.branch !== want.branch) begin
               $display("%0t: branch exp %0d got %0d", $time, want.branch, got.branch);
               n_err++;
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      rsp_type none;
      logic [31:0] mn, mx;
      int i;

      none = '0;
      n_err = 0; n_checked = 0; n_sent = 0; n_dropped = 0;
      n_frozen_eval = 0; n_between = 0;
      no_idle = 1'b0; hold_rsp = 1'b0;
      vmin = 65536; vmax = 131072; knee_open = 0; knee_close = 0;
      pspan = 65536; margin = 0; relax = 0; frozen = 1'b0;
      for (i = 0; i < 16; i++) begin
         bank_vol[i] = '0;
         bank_br[i]  = 1'b0;
      end
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every unit gets loaded first; the last one at the volume extreme
      for (i = 0; i < 15; i++) begin
         row.item  = '{OP_LOAD, 4'(i), 32'sd0, 31'(98304 + i), 1'b0};
         row.typed = 1'b1;
         row.want  = '{31'(98304 + i), 32'sd0, 31'(98304 + i), 1'b0};
         rows.insert(rows.size(), row);
      end
      rows.insert(rows.size(), '{'{OP_LOAD, 4'd15, 32'sh7fffffff, 31'h7fffffff, 1'b1},
                                 1'b1, '{31'h7fffffff, 32'sd0, 31'h7fffffff, 1'b1}});
      rows.insert(rows.size(), '{'{OP_EVAL, 4'd0, 32'sh80000000, 31'd0, 1'b0}, 1'b1,
                                 '{31'd65536, 32'sd0, 31'd65536, 1'b0}});
      rows.insert(rows.size(), '{'{OP_EVAL, 4'd0, 32'sh7fffffff, 31'd0, 1'b0}, 1'b1,
                                 '{31'd131072, 32'sd0, 31'd131072, 1'b0}});
      // pressure right on the lower knee
      rows.insert(rows.size(), '{'{OP_EVAL, 4'd0, 32'sd0, 31'd0, 1'b0}, 1'b1,
                                 '{31'd65536, 32'sd0, 31'd65536, 1'b0}});
      rows.insert(rows.size(), '{'{OP_EVAL, 4'd0, 32'sd32768, 31'd0, 1'b0}, 1'b0, none});
      // full commit flips to closing, empty commit flips back
      rows.insert(rows.size(), '{'{OP_COMMIT, 4'd0, 32'sh7fffffff, 31'd0, 1'b0}, 1'b1,
                                 '{31'd131072, 32'sd0, 31'd131072, 1'b1}});
      rows.insert(rows.size(), '{'{OP_COMMIT, 4'd0, 32'sh80000000, 31'd0, 1'b0}, 1'b1,
                                 '{31'd65536, 32'sd0, 31'd65536, 1'b0}});
      rows.insert(rows.size(), '{'{OP_NONE, 4'd2, 32'shffffffff, 31'h7fffffff, 1'b1},
                                 1'b0, none});
      rows.insert(rows.size(), '{'{OP_COMMIT, 4'd1, 32'sd40000, 31'd0, 1'b0}, 1'b0, none});
      rows.insert(rows.size(), '{'{OP_EVAL, 4'd15, 32'sd65536, 31'd0, 1'b0}, 1'b1,
                                 '{31'd131072, 32'sd0, 31'd131072, 1'b1}});
      foreach (rows[k]) send_req(rows[k].item, rows[k].typed, rows[k].want);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: set_config(32'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1,
                          32'd32767, 32'd65535, 32'd1);
            2: begin
               mn = $urandom_range(65536, 1 << 24);
               set_config(mn, mn - $urandom_range(1, 65536), $urandom, $urandom,
                          $urandom_range(1, 1 << 20), $urandom_range(0, 32767),
                          $urandom_range(0, 65535), 32'd0);
            end
            7: set_config(32'd65536, 32'd131072, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0,
                          32'd0);
            default: begin
               mn = $urandom_range(1, 1 << 22);
               mx = mn + $urandom_range(1, 1 << 24);
               set_config(mn, mx, $urandom_range(0, 1 << 20),
                          32'(-$urandom_range(0, 1 << 20)),
                          $urandom_range(1, (ph == 5) ? 32'h7fffffff : (1 << 20)),
                          $urandom_range(0, 32767),
                          (ph == 4) ? 32'd0 : $urandom_range(0, 65535),
                          32'(ph % 3 == 0));
            end
         endcase
         no_idle = (ph == 3);
         for (i = 0; i < 210; i++) begin
            // receiver holds off while the sender keeps offering beats
            if (i == 60) hold_rsp = 1'b1;
            if (i == 140) drain();
            send_req(random_req(), 1'b0, none);
         end
         drain();
      end

      $display("%0d request beats, %0d responses checked, %0d dropped, %0d between knees,",
               n_sent, n_checked, n_dropped, n_between);
      $display("%0d frozen evaluates over 9 register settings", n_frozen_eval);
      if (n_err == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
